// ----- sv/outlier_rejecting_window_average_core_assert.svh -----
// Assertion macros for the outlier-rejecting window average core.
// Included by the top level; no other dependencies.
`ifndef OUTLIER_REJECTING_WINDOW_AVERAGE_CORE_ASSERT_SVH
`define OUTLIER_REJECTING_WINDOW_AVERAGE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ORWA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("orwa: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define ORWA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("orwa: next-cycle check failed");
`else
`define ORWA_ASSERT_SAME(label, clk, rst, ante, cons)
`define ORWA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/orwa_pkg.sv -----
// Shared types, constants and the microcode ROM of the window average core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package orwa_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TOL_W    = 7;
   localparam int KIND_W   = 2;

   localparam logic [TOL_W-1:0] TOL_RESET = 7'd10;

   localparam logic [KIND_W-1:0] KIND_DISCARD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PASS     = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FILTERED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd3;

   // shared divider: 24-bit dividend, 7-bit divisor, 4 quotient bits per cycle
   localparam int DVD_W      = 24;
   localparam int DSR_W      = 7;
   localparam int DIV_STEPS  = 4;
   localparam int DIV_ROUNDS = DVD_W / DIV_STEPS;
   localparam int DIV_CNT_W  = 3;

   localparam int PROD_W = SAMPLE_W + TOL_W;
   localparam int DEV_W  = 17;
   localparam logic [DSR_W-1:0] PCT_SCALE = 7'd100;

   // sequencer step codes
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] ST_IDLE       = 5'd0;
   localparam logic [STEP_W-1:0] ST_BRANCH     = 5'd1;
   localparam logic [STEP_W-1:0] ST_QUICK      = 5'd2;
   localparam logic [STEP_W-1:0] ST_APPEND     = 5'd3;
   localparam logic [STEP_W-1:0] ST_SUM_RD     = 5'd4;
   localparam logic [STEP_W-1:0] ST_SUM_END    = 5'd5;
   localparam logic [STEP_W-1:0] ST_MEAN_DIV   = 5'd6;
   localparam logic [STEP_W-1:0] ST_MEAN_GET   = 5'd7;
   localparam logic [STEP_W-1:0] ST_MUL        = 5'd8;
   localparam logic [STEP_W-1:0] ST_DEV_DIV    = 5'd9;
   localparam logic [STEP_W-1:0] ST_DEV_GET    = 5'd10;
   localparam logic [STEP_W-1:0] ST_FILT_INIT  = 5'd11;
   localparam logic [STEP_W-1:0] ST_FILT_RD    = 5'd12;
   localparam logic [STEP_W-1:0] ST_FILT_END   = 5'd13;
   localparam logic [STEP_W-1:0] ST_SET_FILL   = 5'd14;
   localparam logic [STEP_W-1:0] ST_AVG_DIV    = 5'd15;
   localparam logic [STEP_W-1:0] ST_AVG_EMIT   = 5'd16;
   localparam logic [STEP_W-1:0] ST_EMPTY_EMIT = 5'd17;

   // hold conditions
   localparam logic [2:0] W_NONE       = 3'd0;
   localparam logic [2:0] W_NO_REQ     = 3'd1;
   localparam logic [2:0] W_OUT_BUSY   = 3'd2;
   localparam logic [2:0] W_DIV_BUSY   = 3'd3;
   localparam logic [2:0] W_DIV_OR_OUT = 3'd4;

   // datapath actions
   localparam logic [3:0] A_NOP        = 4'd0;
   localparam logic [3:0] A_ACCEPT     = 4'd1;
   localparam logic [3:0] A_QUICK      = 4'd2;
   localparam logic [3:0] A_APPEND     = 4'd3;
   localparam logic [3:0] A_MEAN_DIV   = 4'd4;
   localparam logic [3:0] A_MEAN_GET   = 4'd5;
   localparam logic [3:0] A_MUL        = 4'd6;
   localparam logic [3:0] A_DEV_DIV    = 4'd7;
   localparam logic [3:0] A_DEV_GET    = 4'd8;
   localparam logic [3:0] A_FILT_INIT  = 4'd9;
   localparam logic [3:0] A_SET_FILL   = 4'd10;
   localparam logic [3:0] A_AVG_DIV    = 4'd11;
   localparam logic [3:0] A_AVG_EMIT   = 4'd12;
   localparam logic [3:0] A_EMPTY_EMIT = 4'd13;

   // where returning read data goes
   localparam logic [1:0] SINK_NONE = 2'd0;
   localparam logic [1:0] SINK_SUM  = 2'd1;
   localparam logic [1:0] SINK_FILT = 2'd2;

   // jump conditions
   localparam logic [2:0] J_NEXT   = 3'd0;
   localparam logic [2:0] J_ALWAYS = 3'd1;
   localparam logic [2:0] J_LOOP   = 3'd2;
   localparam logic [2:0] J_FULL   = 3'd3;
   localparam logic [2:0] J_EMPTY  = 3'd4;

   typedef struct packed {
      logic [2:0]        wait_sel;
      logic [3:0]        act;
      logic              rd_issue;
      logic [1:0]        sink;
      logic [2:0]        jmp_sel;
      logic [STEP_W-1:0] jmp_to;
   } ucw_type;

   typedef struct packed {
      logic no_req;
      logic out_busy;
      logic div_busy;
      logic full;
      logic cnt_last;
      logic kept_zero;
   } seq_stat_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [DVD_W-1:0] quotient;
      logic [DSR_W-1:0] remainder;
   } div_rsp_type;

   // Microcode ROM: one control word per step.
   function automatic ucw_type ucode(input logic [STEP_W-1:0] step);
      ucw_type w;
      w = '{wait_sel: W_NONE, act: A_NOP, rd_issue: 1'b0, sink: SINK_NONE,
            jmp_sel: J_NEXT, jmp_to: ST_IDLE};
      unique case (step)
         ST_IDLE: begin
            w.wait_sel = W_NO_REQ;
            w.act      = A_ACCEPT;
         end
         ST_BRANCH: begin
            w.jmp_sel = J_FULL;
            w.jmp_to  = ST_APPEND;
         end
         ST_QUICK: begin
            w.wait_sel = W_OUT_BUSY;
            w.act      = A_QUICK;
            w.jmp_sel  = J_ALWAYS;
         end
         ST_APPEND:   w.act = A_APPEND;
         ST_SUM_RD: begin
            w.rd_issue = 1'b1;
            w.sink     = SINK_SUM;
            w.jmp_sel  = J_LOOP;
            w.jmp_to   = ST_SUM_RD;
         end
         ST_SUM_END:  w.sink = SINK_SUM;
         ST_MEAN_DIV: w.act = A_MEAN_DIV;
         ST_MEAN_GET: begin
            w.wait_sel = W_DIV_BUSY;
            w.act      = A_MEAN_GET;
         end
         ST_MUL:      w.act = A_MUL;
         ST_DEV_DIV:  w.act = A_DEV_DIV;
         ST_DEV_GET: begin
            w.wait_sel = W_DIV_BUSY;
            w.act      = A_DEV_GET;
         end
         ST_FILT_INIT: w.act = A_FILT_INIT;
         ST_FILT_RD: begin
            w.rd_issue = 1'b1;
            w.sink     = SINK_FILT;
            w.jmp_sel  = J_LOOP;
            w.jmp_to   = ST_FILT_RD;
         end
         ST_FILT_END: w.sink = SINK_FILT;
         ST_SET_FILL: begin
            w.act     = A_SET_FILL;
            w.jmp_sel = J_EMPTY;
            w.jmp_to  = ST_EMPTY_EMIT;
         end
         ST_AVG_DIV:  w.act = A_AVG_DIV;
         ST_AVG_EMIT: begin
            w.wait_sel = W_DIV_OR_OUT;
            w.act      = A_AVG_EMIT;
            w.jmp_sel  = J_ALWAYS;
         end
         ST_EMPTY_EMIT: begin
            w.wait_sel = W_OUT_BUSY;
            w.act      = A_EMPTY_EMIT;
            w.jmp_sel  = J_ALWAYS;
         end
         default: w.jmp_sel = J_ALWAYS;
      endcase
      return w;
   endfunction

endpackage

// ----- sv/outlier_rejecting_window_average_core.sv -----
// Top level of the outlier-rejecting window average: datapath, window memory,
// result register. Depends on orwa_pkg, orwa_seq, orwa_div and the assert header.
`timescale 1ns / 1ps
`include "outlier_rejecting_window_average_core_assert.svh"
// Usage
// -----
// req_ channel: one 16-bit sample per item (valid/stall). rsp_ channel: one
// result item per sample: filtered value plus a kind code (discarded first,
// pass-through while filling, filtered mean, all rejected). csr_ port: write
// tolerance_pct (percent) while the block is idle; it resets to 10.
// The block works on one item at a time; req_stall is low only in the idle
// step. A finished result sits in the output register, so the next sample is
// taken while an earlier result still waits on a stalled receiver; on the
// output side it only holds to put a new result in a still-occupied register.
// Steps: the first sample and window-filling samples pass the idle, branch
// and quick steps, which load the result register. With a full window an
// item makes two walks over the window memory (one read port) and up to
// three passes through the shared divider at four quotient bits per cycle
// (window mean, mean*tolerance/100, survivor mean); the survivor-mean pass is
// skipped when every sample is rejected. Synchronous reset empties the window,
// re-arms the discard of the first sample and restores the tolerance; window
// contents are kept.
module outlier_rejecting_window_average_core import orwa_pkg::*; #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_filtered_value,
   output logic [KIND_W-1:0]   rsp_result_kind,
   input  logic                csr_write_enable,
   input  logic [TOL_W-1:0]    csr_write_data
);

   localparam int PTR_W = $clog2(WINDOW_LEN);
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W = SAMPLE_W + CNT_W;
   localparam int CMP_W = DEV_W + 1;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(WINDOW_LEN - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // sequencer and divider
   ucw_type      ctrl;
   logic         fire;
   seq_stat_type stat;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   // configuration and window bookkeeping
   logic [TOL_W-1:0]    tol_ff, tol_in;
   logic                first_ff, first_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [PTR_W-1:0]    tail_ff, tail_in;

   // working registers of one full-window item
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    kept_ff, kept_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DEV_W-1:0]    ceil_ff, ceil_in;
   logic [CMP_W-1:0]    upper_ff, upper_in;

   // window memory
   logic [SAMPLE_W-1:0] win_mem [WINDOW_LEN];
   logic                mem_we;
   logic [PTR_W-1:0]    mem_waddr;
   logic [SAMPLE_W-1:0] mem_wdata;
   logic                rd_fire;
   logic [SAMPLE_W-1:0] rdata_ff;
   logic                rvalid_ff, rvalid_in;
   logic                inlier;

   // result register
   logic                emit;
   logic [SAMPLE_W-1:0] emit_value;
   logic [KIND_W-1:0]   emit_kind;
   logic                out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0] out_value_ff, out_value_in;
   logic [KIND_W-1:0]   out_kind_ff, out_kind_in;

   orwa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl),
      .fire  (fire)
   );

   orwa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // only the idle step takes items
   assign req_stall = (ctrl.act != A_ACCEPT);

   assign stat.no_req    = !req_valid;
   assign stat.out_busy  = out_valid_ff && rsp_stall;
   assign stat.div_busy  = div_rsp.busy;
   assign stat.full      = first_ff && (fill_ff == CNT_W'(WINDOW_LEN));
   assign stat.cnt_last  = (cnt_ff == CNT_W'(1));
   assign stat.kept_zero = (kept_ff == '0);

   assign rd_fire = fire && ctrl.rd_issue;

   // reject below mean - ceil(dev) as s + ceil < mean, which never goes negative
   assign inlier = !((CMP_W'(rdata_ff) + CMP_W'(ceil_ff)) < CMP_W'(mean_ff)) &&
                   !(CMP_W'(rdata_ff) > upper_ff);

   always_comb begin
      tol_in    = csr_write_enable ? csr_write_data : tol_ff;
      first_in  = first_ff;
      fill_in   = fill_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      sample_in = sample_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      kept_in   = kept_ff;
      acc_in    = acc_ff;
      mean_in   = mean_ff;
      prod_in   = prod_ff;
      ceil_in   = ceil_ff;
      upper_in  = upper_ff;
      mem_we    = 1'b0;
      mem_waddr = tail_ff;
      mem_wdata = sample_ff;
      emit       = 1'b0;
      emit_value = '0;
      emit_kind  = KIND_DISCARD;
      div_req.start    = 1'b0;
      div_req.dividend = DVD_W'(acc_ff);
      div_req.divisor  = DSR_W'(WINDOW_LEN);
      rvalid_in = rd_fire;

      // advance the read walk
      if (rd_fire) begin
         rd_ptr_in = ptr_inc(rd_ptr_ff);
         cnt_in    = cnt_ff - CNT_W'(1);
      end

      // consume read data in the cycle after the read
      if (rvalid_ff) begin
         case (ctrl.sink)
            SINK_SUM: acc_in = acc_ff + SUM_W'(rdata_ff);
            SINK_FILT: begin
               if (inlier) begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ptr_ff;
                  mem_wdata = rdata_ff;
                  wr_ptr_in = ptr_inc(wr_ptr_ff);
                  kept_in   = kept_ff + CNT_W'(1);
                  acc_in    = acc_ff + SUM_W'(rdata_ff);
               end
            end
            default: ;
         endcase
      end

      if (fire) begin
         unique case (ctrl.act)
            A_ACCEPT: sample_in = req_sample_value;
            A_QUICK: begin
               if (!first_ff) begin
                  // drop the very first sample
                  first_in   = 1'b1;
                  emit       = 1'b1;
                  emit_value = '0;
                  emit_kind  = KIND_DISCARD;
               end else begin
                  mem_we     = 1'b1;
                  mem_waddr  = tail_ff;
                  mem_wdata  = sample_ff;
                  tail_in    = ptr_inc(tail_ff);
                  fill_in    = fill_ff + CNT_W'(1);
                  emit       = 1'b1;
                  emit_value = sample_ff;
                  emit_kind  = KIND_PASS;
               end
            end
            A_APPEND: begin
               // full window: tail equals head, overwrite the oldest entry
               mem_we    = 1'b1;
               mem_waddr = tail_ff;
               mem_wdata = sample_ff;
               head_in   = ptr_inc(head_ff);
               tail_in   = ptr_inc(tail_ff);
               rd_ptr_in = ptr_inc(head_ff);
               cnt_in    = CNT_W'(WINDOW_LEN);
               acc_in    = '0;
            end
            A_MEAN_DIV: begin
               div_req.start    = 1'b1;
               div_req.dividend = DVD_W'(acc_ff);
               div_req.divisor  = DSR_W'(WINDOW_LEN);
            end
            A_MEAN_GET: mean_in = div_rsp.quotient[SAMPLE_W-1:0];
            A_MUL:      prod_in = PROD_W'(mean_ff) * PROD_W'(tol_ff);
            A_DEV_DIV: begin
               div_req.start    = 1'b1;
               div_req.dividend = DVD_W'(prod_ff);
               div_req.divisor  = PCT_SCALE;
            end
            A_DEV_GET: begin
               ceil_in  = div_rsp.quotient[DEV_W-1:0] +
                          DEV_W'(div_rsp.remainder != '0);
               upper_in = CMP_W'(div_rsp.quotient[DEV_W-1:0]) + CMP_W'(mean_ff);
            end
            A_FILT_INIT: begin
               rd_ptr_in = head_ff;
               wr_ptr_in = head_ff;
               cnt_in    = CNT_W'(WINDOW_LEN);
               kept_in   = '0;
               acc_in    = '0;
            end
            A_SET_FILL: begin
               // survivors now sit at the front of the window
               fill_in = kept_ff;
               tail_in = wr_ptr_ff;
            end
            A_AVG_DIV: begin
               div_req.start    = 1'b1;
               div_req.dividend = DVD_W'(acc_ff);
               div_req.divisor  = DSR_W'(kept_ff);
            end
            A_AVG_EMIT: begin
               emit       = 1'b1;
               emit_value = div_rsp.quotient[SAMPLE_W-1:0];
               emit_kind  = KIND_FILTERED;
            end
            A_EMPTY_EMIT: begin
               emit       = 1'b1;
               emit_value = '0;
               emit_kind  = KIND_REJECTED;
            end
            default: ;
         endcase
      end

      // result register: load on emit, empty when the receiver takes it
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      out_kind_in  = out_kind_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_value_in = emit_value;
         out_kind_in  = emit_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         first_ff     <= 1'b0;
         fill_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rvalid_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         tol_ff       <= tol_in;
         first_ff     <= first_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rvalid_ff    <= rvalid_in;
         out_valid_ff <= out_valid_in;
      end
      sample_ff    <= sample_in;
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      cnt_ff       <= cnt_in;
      kept_ff      <= kept_in;
      acc_ff       <= acc_in;
      mean_ff      <= mean_in;
      prod_ff      <= prod_in;
      ceil_ff      <= ceil_in;
      upper_ff     <= upper_in;
      out_value_ff <= out_value_in;
      out_kind_ff  <= out_kind_in;
   end

   // window memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_fire) begin
         rdata_ff <= win_mem[rd_ptr_ff];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_filtered_value = out_value_ff;
   assign rsp_result_kind    = out_kind_ff;

   // a new result never lands on one the receiver has not taken
   `ORWA_ASSERT_SAME(a_emit_free, clock, reset, emit, !(out_valid_ff && rsp_stall))
   // the shared divider is never restarted mid-division
   `ORWA_ASSERT_SAME(a_div_idle_start, clock, reset, div_req.start, !div_rsp.busy)
   // one item at a time: after an accept the input holds off
   `ORWA_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)
   // nothing is stored before the first sample has been dropped
   `ORWA_ASSERT_SAME(a_fill_after_first, clock, reset, !first_ff, fill_ff == '0)

endmodule

// ----- sv/orwa_div.sv -----
// Shared iterative divider, radix-16 restoring, four quotient bits a cycle.
// Depends on orwa_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
module orwa_div import orwa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DSR_W:0]       trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      trial   = '0;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_ROUNDS - 1);
         dvd_in  = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         // dividend register doubles as the quotient shift register
         for (int i = 0; i < DIV_STEPS; i++) begin
            trial  = {rem_in, dvd_in[DVD_W-1]};
            dvd_in = {dvd_in[DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_in}) begin
               trial     = trial - {1'b0, dsr_in};
               dvd_in[0] = 1'b1;
            end
            rem_in = trial[DSR_W-1:0];
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.busy      = busy_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ----- sv/orwa_seq.sv -----
// Microcode sequencer: step counter, ROM lookup, hold and jump logic.
// Depends on orwa_pkg for the control word, status struct and ROM.
`timescale 1ns / 1ps
module orwa_seq import orwa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  seq_stat_type stat,
   output ucw_type      ctrl,
   output logic         fire
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              hold;
   logic              take;

   assign ctrl = ucode(step_ff);

   always_comb begin
      unique case (ctrl.wait_sel)
         W_NONE:       hold = 1'b0;
         W_NO_REQ:     hold = stat.no_req;
         W_OUT_BUSY:   hold = stat.out_busy;
         W_DIV_BUSY:   hold = stat.div_busy;
         W_DIV_OR_OUT: hold = stat.div_busy || stat.out_busy;
         default:      hold = 1'b0;
      endcase
      unique case (ctrl.jmp_sel)
         J_NEXT:   take = 1'b0;
         J_ALWAYS: take = 1'b1;
         J_LOOP:   take = !stat.cnt_last;
         J_FULL:   take = stat.full;
         J_EMPTY:  take = stat.kept_zero;
         default:  take = 1'b0;
      endcase
      fire = !hold;
      if (hold) begin
         step_in = step_ff;
      end else if (take) begin
         step_in = ctrl.jmp_to;
      end else begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
